// File: hdl/stq_pkg.sv
// Shared types and constants for the sorted timer event queue.
package stq_pkg;

   localparam int unsigned HANDLE_W    = 4;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned IDENT_W     = 32;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_REMOVE,
      CMD_INSERT,
      CMD_POP
   } cmd_type;

   typedef struct packed {
      logic                valid;
      logic [TIME_W-1:0]   due_time;
      logic [IDENT_W-1:0]  ident;
      logic [HANDLE_W-1:0] owner;
   } slot_type;

   // broadcast to every cell of the row
   typedef struct packed {
      cmd_type             cmd;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   due_time;
      logic [IDENT_W-1:0]  ident;
   } ctrl_type;

endpackage

// File: hdl/stq_req_if.sv
// Request channel interface: insert, remove and tick words.
interface stq_req_if;
   logic                           valid;
   logic                           ready;
   logic [stq_pkg::MODE_W-1:0]     mode;
   logic [stq_pkg::HANDLE_W-1:0]   handle;
   logic [stq_pkg::TIME_W-1:0]     timestamp;
   logic [stq_pkg::IDENT_W-1:0]    event_id;
   logic [stq_pkg::TIME_W-1:0]     now;

   modport source (output valid, mode, handle, timestamp, event_id, now, input ready);
   modport sink   (input valid, mode, handle, timestamp, event_id, now, output ready);
endinterface

// File: hdl/stq_rsp_if.sv
// Response channel interface: one word per fired event.
interface stq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [stq_pkg::IDENT_W-1:0]    fired_id;
   logic [stq_pkg::HANDLE_W-1:0]   fired_handle;
   logic                           last;

   modport source (output valid, fired_id, fired_handle, last, input ready);
   modport sink   (input valid, fired_id, fired_handle, last, output ready);
endinterface

// File: hdl/stq_cell.sv
// One queue slot: compares against the broadcast command and shifts with its neighbors.
module stq_cell (
   input  logic              clock,
   input  logic              reset,
   input  stq_pkg::ctrl_type ctrl,
   input  stq_pkg::slot_type left,
   input  stq_pkg::slot_type right,
   input  logic              prefix_in,
   output logic              prefix_out,
   output stq_pkg::slot_type slot
);

   stq_pkg::slot_type slot_ff;
   stq_pkg::slot_type slot_in;
   logic [stq_pkg::TIME_W-1:0] diff;
   logic flag;

   // new time minus slot time, negative means the new entry goes in front
   assign diff = ctrl.due_time - slot_ff.due_time;

   always_comb begin
      case (ctrl.cmd)
         stq_pkg::CMD_REMOVE: flag = slot_ff.valid && (slot_ff.owner == ctrl.handle);
         stq_pkg::CMD_INSERT: flag = !slot_ff.valid || diff[stq_pkg::TIME_W-1];
         default:             flag = 1'b0;
      endcase
   end

   assign prefix_out = prefix_in | flag;

   always_comb begin
      slot_in = slot_ff;
      case (ctrl.cmd)
         stq_pkg::CMD_REMOVE: begin
            if (prefix_in || flag) slot_in = right;
         end
         stq_pkg::CMD_INSERT: begin
            if (prefix_in) begin
               slot_in = left;
            end else if (flag) begin
               slot_in.valid    = 1'b1;
               slot_in.due_time = ctrl.due_time;
               slot_in.ident    = ctrl.ident;
               slot_in.owner    = ctrl.handle;
            end
         end
         stq_pkg::CMD_POP: slot_in = right;
         default: slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

// File: hdl/sorted_timer_event_queue.sv
// Sorted timer event queue: a row of compare-and-shift cells kept in due-time order.
//
// req_chan takes insert, remove and tick words (valid/ready). An insert first
// drops any entry with the same handle, then shifts the row open at the first
// later entry (ties go behind). A tick fires up to 16 events, one response word
// each; the last word carries last=1. A tick with nothing due, or with dispatch
// off, gives no response word. Times compare by signed wraparound difference;
// an entry is due when its time minus now is at most zero. An insert into a
// full row is dropped.
// Pacing comes from the single shared command broadcast to all cells and the
// one-word response register: the row changes at most once per cycle.
// Each response word sits in an output register; when rsp_chan stalls the
// popping waits, and req_chan stays low until the tick is finished.
// csr_wr_en/csr_wr_data set dispatch enable; the user must write it only while
// the block is idle, which the block does not enforce. Synchronous reset
// empties the queue, clears dispatch enable and drops any pending response word.
module sorted_timer_event_queue #(
   parameter int unsigned SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   stq_req_if.sink    req_chan,
   stq_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_TICK
   } state_type;

   state_type                     state_ff, state_in;
   logic [stq_pkg::HANDLE_W-1:0]  hold_handle_ff, hold_handle_in;
   logic [stq_pkg::TIME_W-1:0]    hold_time_ff, hold_time_in;
   logic [stq_pkg::IDENT_W-1:0]   hold_ident_ff, hold_ident_in;
   logic [stq_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          enable_ff, enable_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [stq_pkg::IDENT_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [stq_pkg::HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic                          rsp_last_ff, rsp_last_in;

   stq_pkg::ctrl_type ctrl;
   stq_pkg::slot_type cells [SLOTS];
   logic [SLOTS:0]    prefix;

   logic accept, out_free, full;
   logic head_due, next_due, last_pop;
   logic [stq_pkg::TIME_W-1:0] head_diff, next_diff;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign full     = cells[SLOTS-1].valid;

   assign head_diff = cells[0].due_time - hold_time_ff;
   assign next_diff = cells[1].due_time - hold_time_ff;
   assign head_due  = cells[0].valid &&
                      ((head_diff == '0) || head_diff[stq_pkg::TIME_W-1]);
   assign next_due  = cells[1].valid &&
                      ((next_diff == '0) || next_diff[stq_pkg::TIME_W-1]);
   // look one slot ahead so the final word of a tick is known when popped
   assign last_pop  = !((count_ff < stq_pkg::CNT_W'(stq_pkg::MAX_RESULTS - 1)) && next_due);

   always_comb begin
      ctrl.cmd      = stq_pkg::CMD_HOLD;
      ctrl.handle   = hold_handle_ff;
      ctrl.due_time = hold_time_ff;
      ctrl.ident    = hold_ident_ff;
      case (state_ff)
         ST_IDLE: begin
            ctrl.handle = req_chan.handle;
            if (accept && (req_chan.mode == stq_pkg::MODE_INSERT ||
                           req_chan.mode == stq_pkg::MODE_REMOVE))
               ctrl.cmd = stq_pkg::CMD_REMOVE;
         end
         ST_INSERT: begin
            if (!full) ctrl.cmd = stq_pkg::CMD_INSERT;
         end
         ST_TICK: begin
            if (head_due && out_free) ctrl.cmd = stq_pkg::CMD_POP;
         end
         default: ctrl.cmd = stq_pkg::CMD_HOLD;
      endcase
   end

   assign prefix[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      stq_pkg::slot_type left_slot, right_slot;
      if (i == 0) begin : g_first
         assign left_slot = '0;
      end else begin : g_mid_left
         assign left_slot = cells[i-1];
      end
      if (i == SLOTS - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_mid_right
         assign right_slot = cells[i+1];
      end
      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left       (left_slot),
         .right      (right_slot),
         .prefix_in  (prefix[i]),
         .prefix_out (prefix[i+1]),
         .slot       (cells[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      hold_handle_in = hold_handle_ff;
      hold_time_in   = hold_time_ff;
      hold_ident_in  = hold_ident_ff;
      count_in       = count_ff;
      enable_in      = csr_wr_en ? csr_wr_data : enable_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in      = rsp_id_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_handle_in = req_chan.handle;
               hold_ident_in  = req_chan.event_id;
               count_in       = '0;
               if (req_chan.mode == stq_pkg::MODE_INSERT) begin
                  hold_time_in = req_chan.timestamp;
                  state_in     = ST_INSERT;
               end else if (req_chan.mode == stq_pkg::MODE_TICK && enable_ff) begin
                  hold_time_in = req_chan.now;
                  state_in     = ST_TICK;
               end
            end
         end
         ST_INSERT: state_in = ST_IDLE;
         ST_TICK: begin
            if (!head_due) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = cells[0].ident;
               rsp_handle_in = cells[0].owner;
               rsp_last_in   = last_pop;
               count_in      = count_ff + 1'b1;
               if (last_pop) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      hold_handle_ff <= hold_handle_in;
      hold_time_ff   <= hold_time_in;
      hold_ident_ff  <= hold_ident_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fired_id     = rsp_id_ff;
   assign rsp_chan.fired_handle = rsp_handle_ff;
   assign rsp_chan.last         = rsp_last_ff;

endmodule

// File: hdl/stq_checker.sv
// Port-level checks for the sorted timer event queue, bound to the top level.
module stq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [stq_pkg::MODE_W-1:0] req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_last
);

   // a word waiting on the output stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // after an insert is taken, ready drops for the shift-in
   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == stq_pkg::MODE_INSERT |=> !req_ready)
      else $error("request taken during insert");

   // remove never starts a response
   a_remove_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == stq_pkg::MODE_REMOVE |=> !$rose(rsp_valid))
      else $error("response word after remove");

   // more words of this tick follow, so no new request yet
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a tick");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_mode  (req_chan.mode),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last)
);
